@@ hw/rtl/pie_pkg.sv @@
// Shared operation codes, status codes and cell commands for the positional list.
package pie_pkg;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_ERASE  = 3'd1,
    OP_READ   = 3'd2,
    OP_RESIZE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_ERASE,
    CMD_RESIZE,
    CMD_CLEAR
  } cell_cmd_e;

  // Broadcast to every cell of the row in the cycle a transaction is taken.
  typedef struct packed {
    cell_cmd_e cmd;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/pie_cell.sv @@
// One slot of the list: holds an element and shifts to or from its neighbors.
module pie_cell #(
  parameter int ELEM_WIDTH = 32,
  parameter int PW         = 5,
  parameter int INDEX      = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pie_pkg::cell_ctrl_t   ctrl_i,
  input  logic [PW-1:0]         pos_i,
  input  logic [PW-1:0]         used_i,
  input  logic [ELEM_WIDTH-1:0] value_i,
  input  logic [ELEM_WIDTH-1:0] left_i,
  input  logic [ELEM_WIDTH-1:0] right_i,
  output logic [ELEM_WIDTH-1:0] slot_o,
  output logic [ELEM_WIDTH-1:0] rd_o
);
  import pie_pkg::*;

  localparam logic [PW-1:0] Idx  = PW'(INDEX);
  localparam logic [PW-1:0] Idx1 = PW'(INDEX + 1);

  logic [ELEM_WIDTH-1:0] slot_q, slot_d;

  always_comb begin
    slot_d = slot_q;
    case (ctrl_i.cmd)
      CMD_INSERT: begin
        if (Idx == pos_i) begin
          slot_d = value_i;
        end else if (Idx > pos_i && Idx <= used_i) begin
          slot_d = left_i;
        end
      end
      CMD_ERASE: begin
        // top used slot is vacated, the ones from pos up take their upper neighbor
        if (Idx1 == used_i) begin
          slot_d = '0;
        end else if (Idx >= pos_i && Idx < used_i) begin
          slot_d = right_i;
        end
      end
      CMD_RESIZE: begin
        if (Idx >= used_i && Idx < pos_i) begin
          slot_d = '0;
        end
      end
      CMD_CLEAR: begin
        if (Idx < used_i) begin
          slot_d = '0;
        end
      end
      default: begin
        slot_d = slot_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;
  assign rd_o   = (Idx == pos_i) ? slot_q : '0;

endmodule

@@ hw/rtl/positional_insert_erase_list.sv @@
// Top level of the bounded positional list: decode, count register, cell row, result register.
//
// A bounded ordered list of up to DEPTH elements held in a row of cells, one element per cell.
// Each transaction carries one operation: insert at a position (later elements move up), erase
// at a position (later elements move down, the vacated top slot is zeroed), read at an index,
// resize (new slots exposed by growth are zeroed) or clear. Every cell updates in the same clock
// edge from its own value and its neighbors', so one transaction is taken per cycle unless the
// input is stalled, and its result appears in the result register on the following cycle; read
// data comes through a select across all cells. A result waiting under stall holds the input
// off only while the result register stays full. Reset zeroes all slots and the count at once.
module positional_insert_erase_list #(
  parameter int DEPTH      = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [4:0]  position_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] read_value_o,
  output logic [4:0]  count_o
);
  import pie_pkg::*;

  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int PW   = (CNTW > 5) ? CNTW : 5;
  localparam logic [PW-1:0] DepthP = PW'(DEPTH);

  logic [CNTW-1:0] used_q, used_d;
  logic            out_valid_q, out_valid_d;
  logic [1:0]      status_q, status_d;
  logic [31:0]     read_q, read_d;
  logic [4:0]      count_q;

  logic                  take;
  logic [PW-1:0]         pos_ext, used_ext;
  logic [ELEM_WIDTH-1:0] elem_in;
  logic [ELEM_WIDTH-1:0] rd_sel;
  cell_cmd_e             cmd;
  cell_ctrl_t            ctrl;

  logic [ELEM_WIDTH-1:0] slot_w  [DEPTH];
  logic [ELEM_WIDTH-1:0] rd_w    [DEPTH];
  logic [ELEM_WIDTH-1:0] left_w  [DEPTH];
  logic [ELEM_WIDTH-1:0] right_w [DEPTH];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign take       = in_valid_i && !in_stall_o;
  assign pos_ext    = PW'(position_i);
  assign used_ext   = PW'(used_q);
  assign elem_in    = ELEM_WIDTH'(value_i);

  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_sel = rd_sel | rd_w[i];
    end
  end

  always_comb begin
    cmd      = CMD_HOLD;
    status_d = ST_OK;
    read_d   = '0;
    used_d   = used_q;
    unique case (op_i)
      OP_INSERT: begin
        if (pos_ext > used_ext) begin
          status_d = ST_RANGE;
        end else if (used_ext == DepthP) begin
          status_d = ST_FULL;
        end else begin
          cmd    = CMD_INSERT;
          used_d = used_q + CNTW'(1);
          read_d = 32'(elem_in);
        end
      end
      OP_ERASE: begin
        if (pos_ext >= used_ext) begin
          status_d = ST_RANGE;
        end else begin
          cmd    = CMD_ERASE;
          used_d = used_q - CNTW'(1);
        end
      end
      OP_READ: begin
        if (pos_ext >= used_ext) begin
          status_d = ST_RANGE;
        end else begin
          read_d = 32'(rd_sel);
        end
      end
      OP_RESIZE: begin
        if (pos_ext > DepthP) begin
          status_d = ST_RANGE;
        end else begin
          cmd    = CMD_RESIZE;
          used_d = CNTW'(pos_ext);
        end
      end
      OP_CLEAR: begin
        cmd    = CMD_CLEAR;
        used_d = '0;
      end
      default: begin
        cmd = CMD_HOLD;
      end
    endcase
  end

  assign ctrl.cmd    = take ? cmd : CMD_HOLD;
  assign out_valid_d = take || (out_valid_q && out_stall_i);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_w[i] = '0;
    end else begin : g_mid_l
      assign left_w[i] = slot_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w[i] = '0;
    end else begin : g_mid_r
      assign right_w[i] = slot_w[i+1];
    end

    pie_cell #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .PW         (PW),
      .INDEX      (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .pos_i   (pos_ext),
      .used_i  (used_ext),
      .value_i (elem_in),
      .left_i  (left_w[i]),
      .right_i (right_w[i]),
      .slot_o  (slot_w[i]),
      .rd_o    (rd_w[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        used_q <= used_d;
      end
    end
  end

  // result payload, loaded with the transaction
  always_ff @(posedge clk_i) begin
    if (take) begin
      status_q <= status_d;
      read_q   <= read_d;
      count_q  <= 5'(used_d);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign read_value_o = read_q;
  assign count_o      = count_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNTW'(DEPTH))
    else $error("element count above depth");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> count_o == 5'(DEPTH))
    else $error("full status with list not full");

  a_erase_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && op_i == OP_ERASE && pos_ext < used_ext |=> used_q == $past(used_q) - CNTW'(1))
    else $error("erase did not drop count");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> read_value_o == 32'd0)
    else $error("rejected transaction returned data");

endmodule
